// ----- rtl/linear_interp_pitch_resampler_defines.svh -----
// Assertion helpers used by the resampler control RTL
`ifndef LINEAR_INTERP_PITCH_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_PITCH_RESAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define LIPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define LIPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lipr_pkg.sv -----
package lipr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 19;
    localparam int TOTAL_W    = 20;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int CNT_W      = 4;

    localparam logic [STEP_W-1:0] STEP_MIN = 19'd16384;
    localparam logic [STEP_W-1:0] STEP_MAX = 19'd262144;

    // results per input frame are capped at eight
    localparam logic [CNT_W-1:0] MAX_RES  = 4'd8;
    localparam logic [CNT_W-1:0] LAST_RES = 4'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic accept;
        logic emit;
        logic finish;
        logic last_of_run;
    } t_cmd;

    typedef struct packed {
        logic more_now;
        logic more_next;
    } t_status;

    // s0 + floor(frac * (s1 - s0) / 2^16); always lies between s0 and s1
    function automatic logic signed [SAMPLE_W-1:0] lerp(
        input logic signed [SAMPLE_W-1:0] s0,
        input logic signed [SAMPLE_W-1:0] s1,
        input logic [FRAC_W-1:0]          frac
    );
        logic signed [SAMPLE_W:0]     diff;
        logic signed [2*SAMPLE_W+1:0] prod;
        logic signed [2*SAMPLE_W+1:0] shifted;
        logic signed [SAMPLE_W+1:0]   sum;
        diff    = $signed({s1[SAMPLE_W-1], s1}) - $signed({s0[SAMPLE_W-1], s0});
        prod    = $signed({1'b0, frac}) * diff;
        shifted = prod >>> FRAC_W;
        sum     = $signed({{2{s0[SAMPLE_W-1]}}, s0}) + shifted[SAMPLE_W+1:0];
        return sum[SAMPLE_W-1:0];
    endfunction

endpackage

// ----- rtl/lipr_dp.sv -----
module lipr_dp #(
    parameter int FRAME_BITS = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lipr_pkg::t_cmd                        i_cmd,
    output lipr_pkg::t_status                     o_status,
    input  logic [lipr_pkg::STEP_W-1:0]           i_step,
    input  logic [lipr_pkg::TOTAL_W-1:0]          i_total,
    input  logic                                  i_stereo,
    input  logic signed [lipr_pkg::SAMPLE_W-1:0]  i_left_sample,
    input  logic signed [lipr_pkg::SAMPLE_W-1:0]  i_right_sample,
    output logic signed [lipr_pkg::SAMPLE_W-1:0]  o_left_out,
    output logic signed [lipr_pkg::SAMPLE_W-1:0]  o_right_out,
    output logic                                  o_last_of_run,
    output logic                                  o_end_of_buffer
);

    localparam int POS_W  = FRAME_BITS + lipr_pkg::FRAC_W;
    localparam int WIDE_W = (FRAME_BITS > lipr_pkg::TOTAL_W) ? FRAME_BITS : lipr_pkg::TOTAL_W;
    localparam int IDX_W  = WIDE_W + 1;
    localparam int CMP_W  = WIDE_W + lipr_pkg::FRAC_W + 2;

    logic signed [lipr_pkg::SAMPLE_W-1:0] r_prev_left, r_prev_right;
    logic signed [lipr_pkg::SAMPLE_W-1:0] r_cur_left, r_cur_right;
    logic [FRAME_BITS-1:0]                r_frame_idx;
    logic [POS_W-1:0]                     r_pos;
    logic signed [lipr_pkg::SAMPLE_W-1:0] r_left_out, r_right_out;
    logic                                 r_last_of_run, r_end_of_buffer;

    logic [lipr_pkg::STEP_W-1:0]          step_c;
    logic [lipr_pkg::TOTAL_W-1:0]         total_eff;
    logic                                 last_frame;
    logic [CMP_W-1:0]                     pos_w, pos1, pos2, limit;
    logic [CMP_W-1:0]                     upper1, upper2, upper;
    logic                                 span1;
    logic signed [lipr_pkg::SAMPLE_W-1:0] s0_l, s1_l, s0_r, s1_r;
    logic signed [lipr_pkg::SAMPLE_W-1:0] lerp_l, lerp_r;

    always_comb begin
        if (i_step < lipr_pkg::STEP_MIN) begin
            step_c = lipr_pkg::STEP_MIN;
        end else if (i_step > lipr_pkg::STEP_MAX) begin
            step_c = lipr_pkg::STEP_MAX;
        end else begin
            step_c = i_step;
        end
        total_eff  = (i_total == '0) ? lipr_pkg::TOTAL_W'(1) : i_total;
        last_frame = (IDX_W'(r_frame_idx) + IDX_W'(1)) >= IDX_W'(total_eff);

        pos_w  = CMP_W'(r_pos);
        pos1   = pos_w + CMP_W'(step_c);
        pos2   = pos1 + CMP_W'(step_c);
        limit  = CMP_W'(total_eff) << lipr_pkg::FRAC_W;
        upper1 = CMP_W'(r_frame_idx) << lipr_pkg::FRAC_W;
        upper2 = (CMP_W'(r_frame_idx) + CMP_W'(1)) << lipr_pkg::FRAC_W;
        upper  = last_frame ? upper2 : upper1;

        o_status.more_now  = (pos_w < upper) && (pos1 <= limit);
        o_status.more_next = (pos1 < upper) && (pos2 <= limit);

        // below the current frame: previous to current; beyond it: current to zero
        span1 = pos_w < upper1;
        s0_l  = span1 ? r_prev_left  : r_cur_left;
        s1_l  = span1 ? r_cur_left   : '0;
        s0_r  = span1 ? r_prev_right : r_cur_right;
        s1_r  = span1 ? r_cur_right  : '0;

        lerp_l = lipr_pkg::lerp(s0_l, s1_l, r_pos[lipr_pkg::FRAC_W-1:0]);
        lerp_r = i_stereo ? lipr_pkg::lerp(s0_r, s1_r, r_pos[lipr_pkg::FRAC_W-1:0]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_left  <= '0;
            r_prev_right <= '0;
            r_frame_idx  <= '0;
            r_pos        <= '0;
        end else if (i_cmd.finish && last_frame) begin
            r_prev_left  <= '0;
            r_prev_right <= '0;
            r_frame_idx  <= '0;
            r_pos        <= '0;
        end else begin
            if (i_cmd.emit) begin
                r_pos <= pos1[POS_W-1:0];
            end
            if (i_cmd.finish) begin
                r_prev_left  <= r_cur_left;
                r_prev_right <= r_cur_right;
                r_frame_idx  <= r_frame_idx + FRAME_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur_left  <= i_left_sample;
            r_cur_right <= i_right_sample;
        end
        if (i_cmd.emit) begin
            r_left_out      <= lerp_l;
            r_right_out     <= lerp_r;
            r_last_of_run   <= i_cmd.last_of_run;
            r_end_of_buffer <= pos2 > limit;
        end
    end

    assign o_left_out      = r_left_out;
    assign o_right_out     = r_right_out;
    assign o_last_of_run   = r_last_of_run;
    assign o_end_of_buffer = r_end_of_buffer;

endmodule

// ----- rtl/lipr_ctrl.sv -----
`include "linear_interp_pitch_resampler_defines.svh"

module lipr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  lipr_pkg::t_status i_status,
    output lipr_pkg::t_cmd    o_cmd
);

    lipr_pkg::t_state              r_state, n_state;
    logic [lipr_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_out_valid, n_out_valid;
    logic                          slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lipr_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            lipr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_cnt        = '0;
                    n_state      = lipr_pkg::ST_RUN;
                end
            end
            lipr_pkg::ST_RUN: begin
                if (!(i_status.more_now && (r_cnt < lipr_pkg::MAX_RES))) begin
                    // frame gives no result at all
                    o_cmd.finish = 1'b1;
                    n_state      = lipr_pkg::ST_IDLE;
                end else if (slot_free) begin
                    o_cmd.emit        = 1'b1;
                    n_cnt             = r_cnt + lipr_pkg::CNT_W'(1);
                    o_cmd.last_of_run = !(i_status.more_next && (r_cnt < lipr_pkg::LAST_RES));
                    if (o_cmd.last_of_run) begin
                        o_cmd.finish = 1'b1;
                        n_state      = lipr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = lipr_pkg::ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    assign o_out_valid = r_out_valid;

    `LIPR_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= lipr_pkg::MAX_RES, "result count beyond cap")
    `LIPR_ASSERT_NOW(a_emit_slot, i_clk, i_rst_n, o_cmd.emit, slot_free, "result overwrites pending request")
    `LIPR_ASSERT_NOW(a_last_ends, i_clk, i_rst_n, o_cmd.emit && o_cmd.last_of_run, o_cmd.finish, "final result without frame close")
    `LIPR_ASSERT_NEXT(a_accept_run, i_clk, i_rst_n, o_cmd.accept, r_cnt == '0 && !o_in_ready, "frame start not clean")

endmodule

// ----- rtl/linear_interp_pitch_resampler.sv -----
// Linear-interpolation resampler for stereo 16-bit frames. Write step (Q3.16, saturated to
// 0.25..4.0), total_frames and stereo while the block is idle, then stream the buffer's frames
// in. Output frame f sits at source position f*step; each input frame is accepted while idle and
// then held until its results are formed and it closes (at once when it causes none); no new
// frame is taken before then. The single interpolation datapath forms one two-lane output frame
// per cycle while the output side does not stall. At most eight results come from one frame;
// last_of_run marks the final one and end_of_buffer the buffer's last.
// All position state clears after the last frame of the buffer.
module linear_interp_pitch_resampler #(
    parameter int FRAME_BITS = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lipr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lipr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [lipr_pkg::SAMPLE_W-1:0]  i_left_sample,
    input  logic signed [lipr_pkg::SAMPLE_W-1:0]  i_right_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [lipr_pkg::SAMPLE_W-1:0]  o_left_out,
    output logic signed [lipr_pkg::SAMPLE_W-1:0]  o_right_out,
    output logic                                  o_last_of_run,
    output logic                                  o_end_of_buffer
);

    logic [lipr_pkg::STEP_W-1:0]  r_step;
    logic [lipr_pkg::TOTAL_W-1:0] r_total;
    logic                         r_stereo;
    lipr_pkg::t_cmd               cmd;
    lipr_pkg::t_status            status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= lipr_pkg::STEP_W'(65536);
            r_total  <= lipr_pkg::TOTAL_W'(1);
            r_stereo <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lipr_pkg::CFG_STEP:   r_step   <= i_cfg_data[lipr_pkg::STEP_W-1:0];
                lipr_pkg::CFG_TOTAL:  r_total  <= i_cfg_data[lipr_pkg::TOTAL_W-1:0];
                lipr_pkg::CFG_STEREO: r_stereo <= i_cfg_data[0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    lipr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lipr_dp #(
        .FRAME_BITS (FRAME_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_step          (r_step),
        .i_total         (r_total),
        .i_stereo        (r_stereo),
        .i_left_sample   (i_left_sample),
        .i_right_sample  (i_right_sample),
        .o_left_out      (o_left_out),
        .o_right_out     (o_right_out),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_buffer (o_end_of_buffer)
    );

endmodule
